// ===== src/stepper_move_sequencer_assert.svh =====
// Assertion macros for the stepper move sequencer port checker.
`ifndef STEPPER_MOVE_SEQUENCER_ASSERT_SVH
`define STEPPER_MOVE_SEQUENCER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while reset is held.
`define SMS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stepper move sequencer check failed");

// Next-cycle implication, sampled on clk, off while reset is held.
`define SMS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stepper move sequencer check failed");

`endif

// ===== src/smseq_pkg.sv =====
// Package with the request and result types and constants of the stepper move sequencer.
package smseq_pkg;

  // Pattern cycles in one revolution, and pattern cycles between LED moves.
  localparam int CYCLES_PER_REV = 512;
  localparam int CYCLES_PER_LED = 64;

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_TICK  = 2'd1,
    OP_ABORT = 2'd2
  } smseq_op_t;

  // One request.
  typedef struct packed {
    smseq_op_t   op;
    logic [6:0]  revolutions;
    logic        counter_clockwise;
    logic        half_step;
  } smseq_in_t;

  // One result.
  typedef struct packed {
    logic [3:0]  coil_pattern;
    logic [7:0]  progress_leds;
    logic [6:0]  revolutions_left;
    logic        busy_res;
    logic        move_done;
  } smseq_out_t;

endpackage

// ===== src/stepper_move_sequencer.sv =====
// Stepper motor move sequencer: full or half step coil drive with progress LEDs.
//
//   channel | ports                          | moves
//   --------+--------------------------------+-------------------------------
//   in      | in_valid, in_stall, in_data    | start, tick or abort
//   out     | out_valid, out_stall, out_data | coils, LEDs, revs left, status
//   cfg     | cfg_we, cfg_wdata              | phase hold in ticks
//
// The state update and the result of a request are computed in one pass and land in
// the state registers and the result register at the same edge.
// A new request is taken each cycle while the result register is empty or being taken.
// Reset is synchronous and active low; the phase hold comes up as five ticks.
// A stalled result holds in the result register and stalls the input side.
module stepper_move_sequencer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  smseq_pkg::smseq_in_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output smseq_pkg::smseq_out_t out_data,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_wdata
);
  import smseq_pkg::*;

  localparam int REV_CW = (CYCLES_PER_REV > 1) ? $clog2(CYCLES_PER_REV) : 1;
  localparam int LED_CW = (CYCLES_PER_LED > 1) ? $clog2(CYCLES_PER_LED) : 1;
  localparam logic [REV_CW-1:0] REV_LAST = REV_CW'(CYCLES_PER_REV - 1);
  localparam logic [LED_CW-1:0] LED_LAST = LED_CW'(CYCLES_PER_LED - 1);

  // Clockwise coil patterns; counter-clockwise reads them backward.
  localparam logic [3:0] FULL_CW [4] = '{4'h8, 4'h4, 4'h2, 4'h1};
  localparam logic [3:0] HALF_CW [8] = '{4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9};

  function automatic logic [3:0] pattern_at(logic [2:0] idx, logic half, logic ccw);
    logic [2:0] k;
    k = 3'd0;
    if (half) begin
      k = ccw ? (3'd7 - idx) : idx;
      pattern_at = HALF_CW[k];
    end else begin
      k[1:0] = ccw ? (2'd3 - idx[1:0]) : idx[1:0];
      pattern_at = FULL_CW[k[1:0]];
    end
  endfunction

  // One LED move: right with wrap when clockwise, left with wrap otherwise.
  function automatic logic [7:0] led_advance(logic [7:0] led, logic ccw);
    if (ccw) begin
      led_advance = (led == 8'h00 || led >= 8'h80) ? 8'h01 : {led[6:0], 1'b0};
    end else begin
      led_advance = (led <= 8'h01 || led > 8'h80) ? 8'h80 : {1'b0, led[7:1]};
    end
  endfunction

  logic [7:0]        hold_r;
  logic              running_r, running_nxt;
  logic              ccw_r, ccw_nxt;
  logic              half_r, half_nxt;
  logic [7:0]        tick_r, tick_nxt;
  logic [2:0]        phase_r, phase_nxt;
  logic [REV_CW-1:0] cycle_r, cycle_nxt;
  logic [LED_CW-1:0] ledcnt_r, ledcnt_nxt;
  logic [6:0]        revs_done_r, revs_done_nxt;
  logic [6:0]        revs_tgt_r, revs_tgt_nxt;
  logic [7:0]        led_r, led_nxt;
  logic [3:0]        coils_r, coils_nxt;
  logic              done;
  logic [7:0]        tick_inc;
  logic [3:0]        phase_inc;
  logic [3:0]        num_phases;
  logic [6:0]        revs_inc;
  logic              in_acc;
  smseq_out_t        res_nxt;
  smseq_out_t        out_data_r;
  logic              out_valid_r;

  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Next state and result for the request at the input.
  always_comb begin
    running_nxt   = running_r;
    ccw_nxt       = ccw_r;
    half_nxt      = half_r;
    tick_nxt      = tick_r;
    phase_nxt     = phase_r;
    cycle_nxt     = cycle_r;
    ledcnt_nxt    = ledcnt_r;
    revs_done_nxt = revs_done_r;
    revs_tgt_nxt  = revs_tgt_r;
    led_nxt       = led_r;
    coils_nxt     = coils_r;
    done          = 1'b0;
    tick_inc      = tick_r + 8'd1;
    phase_inc     = {1'b0, phase_r} + 4'd1;
    num_phases    = half_r ? 4'd8 : 4'd4;
    revs_inc      = revs_done_r + 7'd1;
    unique case (in_data.op)
      OP_START: begin
        ccw_nxt       = in_data.counter_clockwise;
        half_nxt      = in_data.half_step;
        tick_nxt      = 8'd0;
        phase_nxt     = 3'd0;
        cycle_nxt     = '0;
        ledcnt_nxt    = '0;
        revs_done_nxt = 7'd0;
        revs_tgt_nxt  = in_data.revolutions;
        led_nxt       = 8'h00;
        if (in_data.revolutions == 7'd0) begin
          running_nxt = 1'b0;
          done        = 1'b1;
        end else begin
          running_nxt = 1'b1;
          coils_nxt   = pattern_at(3'd0, in_data.half_step, in_data.counter_clockwise);
        end
      end
      OP_TICK: begin
        if (running_r) begin
          tick_nxt = tick_inc;
          if (tick_inc >= hold_r) begin
            tick_nxt = 8'd0;
            if (phase_inc >= num_phases) begin
              // One pattern cycle completed.
              phase_nxt = 3'd0;
              if (ledcnt_r == '0) begin
                led_nxt = led_advance(led_r, ccw_r);
              end
              ledcnt_nxt = (ledcnt_r == LED_LAST) ? '0 : ledcnt_r + 1'b1;
              if (cycle_r == REV_LAST) begin
                // One revolution completed.
                cycle_nxt     = '0;
                ledcnt_nxt    = '0;
                revs_done_nxt = revs_inc;
                if (revs_inc >= revs_tgt_r) begin
                  running_nxt = 1'b0;
                  led_nxt     = 8'h00;
                  done        = 1'b1;
                end
              end else begin
                cycle_nxt = cycle_r + 1'b1;
              end
            end else begin
              phase_nxt = phase_inc[2:0];
            end
            if (running_nxt) begin
              coils_nxt = pattern_at(phase_nxt, half_r, ccw_r);
            end
          end
        end
      end
      OP_ABORT: begin
        if (running_r) begin
          running_nxt = 1'b0;
          led_nxt     = 8'h00;
          done        = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res_nxt.coil_pattern     = coils_nxt;
    res_nxt.progress_leds    = led_nxt;
    res_nxt.revolutions_left = running_nxt ? (revs_tgt_nxt - revs_done_nxt) : 7'd0;
    res_nxt.busy_res         = running_nxt;
    res_nxt.move_done        = done;
  end

  // Phase hold register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 8'd5;
    end else if (cfg_we) begin
      hold_r <= cfg_wdata;
    end
  end

  // Move state, updated on each accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      ccw_r       <= 1'b0;
      half_r      <= 1'b0;
      tick_r      <= 8'd0;
      phase_r     <= 3'd0;
      cycle_r     <= '0;
      ledcnt_r    <= '0;
      revs_done_r <= 7'd0;
      revs_tgt_r  <= 7'd0;
      led_r       <= 8'h00;
      coils_r     <= 4'h0;
    end else if (in_acc) begin
      running_r   <= running_nxt;
      ccw_r       <= ccw_nxt;
      half_r      <= half_nxt;
      tick_r      <= tick_nxt;
      phase_r     <= phase_nxt;
      cycle_r     <= cycle_nxt;
      ledcnt_r    <= ledcnt_nxt;
      revs_done_r <= revs_done_nxt;
      revs_tgt_r  <= revs_tgt_nxt;
      led_r       <= led_nxt;
      coils_r     <= coils_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= res_nxt;
    end
  end

endmodule

// ===== src/smseq_checker.sv =====
// Port checker for the stepper move sequencer and its bind to the top level.
module smseq_assert_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input smseq_pkg::smseq_out_t out_data
);
  import smseq_pkg::*;
  `include "stepper_move_sequencer_assert.svh"

  logic idle_shown;
  logic idle_dark;

  // An idle result, and the cleared LED and revolution fields it must show.
  assign idle_shown = out_valid && !out_data.busy_res;
  assign idle_dark  = (out_data.progress_leds == 8'h00) && (out_data.revolutions_left == 7'd0);

  // A stalled result stays put.
  `SMS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // Every accepted request shows a result on the next cycle.
  `SMS_ASSERT_NXT(a_accept_res, in_valid && !in_stall, out_valid)

  // An idle block shows no LED and no revolutions left.
  `SMS_ASSERT_IMP(a_idle_clear, idle_shown, idle_dark)

  // The progress LED byte is one-hot or dark.
  `SMS_ASSERT_IMP(a_led_onehot, out_valid, $onehot0(out_data.progress_leds))

  // A move that finishes or aborts leaves the block idle.
  `SMS_ASSERT_IMP(a_done_idle, out_valid && out_data.move_done, !out_data.busy_res)

endmodule

bind stepper_move_sequencer smseq_assert_checker u_smseq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/smseq_checker.sv =====
// Checker that predicts and compares every result of the stepper move sequencer.
module smseq_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  smseq_pkg::smseq_in_t  in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  smseq_pkg::smseq_out_t out_data,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_wdata,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import smseq_pkg::*;

  localparam int REPORT_LIMIT = 10;
  localparam logic [7:0] HOLD_AT_RESET = 8'd5;

  // Predicted motor state and the phase hold setting.
  logic       moving;
  logic       ccw_dir;
  logic       half_drive;
  logic [7:0] ticks_held;
  logic [2:0] step_pos;
  logic [8:0] cycles_in_rev;
  logic [6:0] revs_turned;
  logic [6:0] revs_wanted;
  logic [7:0] led_byte;
  logic [3:0] coil_drive;
  logic [7:0] hold_setting;

  // Results predicted for accepted requests, oldest first.
  smseq_out_t coil_results_q[$];
  smseq_out_t want;
  smseq_out_t next_result;

  // Coil lines for a position in the pattern; counter-clockwise walks it backward.
  function automatic logic [3:0] coil_for(logic [2:0] pos, logic half, logic ccw);
    logic [2:0] k;
    k = half ? pos : {1'b0, pos[1:0]};
    if (ccw) begin
      k = half ? 3'd7 - k : 3'd3 - k;
    end
    if (half) begin
      case (k)
        3'd0: return 4'h8;
        3'd1: return 4'hc;
        3'd2: return 4'h4;
        3'd3: return 4'h6;
        3'd4: return 4'h2;
        3'd5: return 4'h3;
        3'd6: return 4'h1;
        default: return 4'h9;
      endcase
    end
    case (k[1:0])
      2'd0: return 4'h8;
      2'd1: return 4'h4;
      2'd2: return 4'h2;
      default: return 4'h1;
    endcase
  endfunction

  // One place of progress LED motion, wrapping at either end.
  function automatic logic [7:0] shift_led(logic [7:0] led, logic ccw);
    if (ccw) begin
      return (led == 8'h00 || led >= 8'h80) ? 8'h01 : led << 1;
    end
    return (led <= 8'h01 || led > 8'h80) ? 8'h80 : led >> 1;
  endfunction

  task automatic reset_motor();
    moving = 1'b0;
    ccw_dir = 1'b0;
    half_drive = 1'b0;
    ticks_held = '0;
    step_pos = '0;
    cycles_in_rev = '0;
    revs_turned = '0;
    revs_wanted = '0;
    led_byte = '0;
    coil_drive = '0;
    hold_setting = HOLD_AT_RESET;
  endtask

  // Apply one request to the predicted state and form its result.
  task automatic step_motor(input smseq_in_t req, output smseq_out_t res);
    logic [3:0] next_pos;
    logic [9:0] next_cycle;
    logic       finished;
    finished = 1'b0;
    case (req.op)
      OP_START: begin
        ccw_dir = req.counter_clockwise;
        half_drive = req.half_step;
        ticks_held = '0;
        step_pos = '0;
        cycles_in_rev = '0;
        revs_turned = '0;
        revs_wanted = req.revolutions;
        led_byte = '0;
        if (req.revolutions == 7'd0) begin
          moving = 1'b0;
          finished = 1'b1;
        end else begin
          moving = 1'b1;
          coil_drive = coil_for(3'd0, half_drive, ccw_dir);
        end
      end
      OP_TICK: begin
        if (moving) begin
          ticks_held = ticks_held + 8'd1;
          // A phase ends once its tick count reaches the current hold; zero acts as one.
          if (ticks_held >= hold_setting) begin
            ticks_held = '0;
            next_pos = {1'b0, step_pos} + 4'd1;
            if (next_pos >= (half_drive ? 4'd8 : 4'd4)) begin
              step_pos = '0;
              if (cycles_in_rev % CYCLES_PER_LED == 0) begin
                led_byte = shift_led(led_byte, ccw_dir);
              end
              next_cycle = {1'b0, cycles_in_rev} + 10'd1;
              if (next_cycle >= CYCLES_PER_REV) begin
                cycles_in_rev = '0;
                revs_turned = revs_turned + 7'd1;
                if (revs_turned >= revs_wanted) begin
                  moving = 1'b0;
                  led_byte = '0;
                  finished = 1'b1;
                end
              end else begin
                cycles_in_rev = next_cycle[8:0];
              end
            end else begin
              step_pos = next_pos[2:0];
            end
            if (moving) begin
              coil_drive = coil_for(step_pos, half_drive, ccw_dir);
            end
          end
        end
      end
      OP_ABORT: begin
        if (moving) begin
          moving = 1'b0;
          led_byte = '0;
          finished = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.coil_pattern = coil_drive;
    res.progress_leds = led_byte;
    res.revolutions_left = moving ? revs_wanted - revs_turned : 7'd0;
    res.busy_res = moving;
    res.move_done = finished;
  endtask

  // Results are compared before the request of the same edge is predicted.
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_motor();
      coil_results_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (coil_results_q.size() == 0) begin
          if (fail_count < REPORT_LIMIT) begin
            $display("%0t: unexpected result coil=%h led=%h left=%0d busy=%b done=%b",
                     $realtime, out_data.coil_pattern, out_data.progress_leds,
                     out_data.revolutions_left, out_data.busy_res, out_data.move_done);
          end
          fail_count++;
        end else begin
          want = coil_results_q.pop_front();
          if (out_data.coil_pattern !== want.coil_pattern ||
              out_data.progress_leds !== want.progress_leds ||
              out_data.revolutions_left !== want.revolutions_left ||
              out_data.busy_res !== want.busy_res ||
              out_data.move_done !== want.move_done) begin
            if (fail_count < REPORT_LIMIT) begin
              $display("%0t: mismatch coil %h/%h led %h/%h left %0d/%0d busy %b/%b done %b/%b",
                       $realtime, want.coil_pattern, out_data.coil_pattern,
                       want.progress_leds, out_data.progress_leds,
                       want.revolutions_left, out_data.revolutions_left,
                       want.busy_res, out_data.busy_res,
                       want.move_done, out_data.move_done);
            end
            fail_count++;
          end
        end
      end
      // A request at the same edge as a hold write still sees the old hold.
      if (in_valid && !in_stall) begin
        step_motor(in_data, next_result);
        coil_results_q.push_back(next_result);
      end
      if (cfg_we) begin
        hold_setting = cfg_wdata;
      end
    end
    pending = coil_results_q.size();
  end

endmodule

// ===== tb/tb.sv =====
// Top of the stepper move sequencer testbench: clock, reset, requests, stalls and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import smseq_pkg::*;

  localparam logic [1:0] OP_CODE_SPARE = 2'd3;
  localparam int NUM_PHASES = 6;
  localparam int RANDOM_REQUESTS = 960;
  localparam int DIRECTED_TICKS = 40;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int QUIET_LIMIT = 3000;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  smseq_in_t  in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  smseq_out_t out_data;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  int fail_count;
  int pending;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int holdoff_req = 0;
  int holdoff_seen = 0;
  int holdoff_left = 0;
  int quiet_cycles = 0;
  logic [7:0] hold_now = 8'd5;

  stepper_move_sequencer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  smseq_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: a long hold-off when asked, random stalls otherwise.
  always @(negedge clk) begin
    if (holdoff_req != holdoff_seen) begin
      holdoff_seen = holdoff_req;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left > 0) begin
      out_stall <= 1'b1;
      holdoff_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Give up when neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic smseq_in_t make_req(logic [1:0] op, logic [6:0] revs, logic ccw,
                                         logic half);
    smseq_in_t req;
    req.op = smseq_op_t'(op);
    req.revolutions = revs;
    req.counter_clockwise = ccw;
    req.half_step = half;
    return req;
  endfunction

  // A tick whose unused fields carry random bits.
  function automatic smseq_in_t tick_req();
    return make_req(OP_TICK, 7'($urandom), 1'($urandom), 1'($urandom));
  endfunction

  // Mostly ticks, with starts, aborts and the spare op code mixed in.
  function automatic smseq_in_t random_req();
    int         pick;
    int         size_pick;
    logic [6:0] revs;
    pick = $urandom_range(0, 99);
    size_pick = $urandom_range(0, 9);
    revs = (size_pick == 0) ? 7'd0 :
           (size_pick <= 5) ? 7'($urandom_range(1, 3)) : 7'($urandom_range(0, 127));
    if (pick < 8) begin
      return make_req(OP_START, revs, 1'($urandom), 1'($urandom));
    end
    if (pick < 11) begin
      return make_req(OP_ABORT, 7'($urandom), 1'($urandom), 1'($urandom));
    end
    if (pick < 13) begin
      return make_req(OP_CODE_SPARE, 7'($urandom), 1'($urandom), 1'($urandom));
    end
    return tick_req();
  endfunction

  // Offer one request after an optional random gap and hold it until taken.
  task automatic send(input smseq_in_t req);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_hold(input logic [7:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    hold_now = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idle(input idle_mode_t mode);
    send_gap_pct = (mode == IDLE_SEND) ? 64 : (mode == IDLE_BOTH) ? 26 : 0;
    recv_stall_pct = (mode == IDLE_RECV) ? 64 : (mode == IDLE_BOTH) ? 26 : 0;
  endtask

  // A start followed by a run of ticks.
  task automatic run_move(input logic [6:0] revs, input logic ccw, input logic half,
                          input int ticks);
    send(make_req(OP_START, revs, ccw, half));
    repeat (ticks) send(tick_req());
  endtask

  initial begin
    logic [7:0] hold_pick;
    logic       ccw;
    logic       half;
    logic [6:0] revs;
    int         ticks;
    int         steps;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests under the reset hold of five ticks.
    send(make_req(OP_TICK, 7'd0, 1'b0, 1'b0));
    send(make_req(OP_ABORT, 7'd0, 1'b0, 1'b0));
    send(make_req(OP_CODE_SPARE, 7'd127, 1'b1, 1'b1));
    send(make_req(OP_START, 7'd0, 1'b1, 1'b0));
    run_move(7'd127, 1'b0, 1'b0, 5);
    send(make_req(OP_CODE_SPARE, 7'd0, 1'b0, 1'b0));
    // A start while running drops the old move.
    run_move(7'd1, 1'b1, 1'b1, 5);
    send(make_req(OP_ABORT, 7'd127, 1'b1, 1'b1));
    send(make_req(OP_TICK, 7'd127, 1'b1, 1'b1));
    run_move(7'd127, 1'b1, 1'b1, 6);
    send(make_req(OP_START, 7'd0, 1'b0, 1'b1));

    // Each phase has its own hold and idling; a move may still run across the write.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: hold_pick = 8'd1;
        1: hold_pick = 8'd0;
        2: hold_pick = 8'd255;
        3: hold_pick = 8'd2;
        4: hold_pick = 8'($urandom_range(3, 6));
        default: hold_pick = 8'd1;
      endcase
      write_hold(hold_pick);
      set_idle(idle_mode_t'(p % 4));
      if (p == 2) begin
        holdoff_req++;
      end

      ccw = (p == 1 || p == 3) ? 1'b1 : (p == 0 || p == 5) ? 1'b0 : 1'($urandom);
      half = (p == 1 || p == 5) ? 1'b1 : (p == 0 || p == 3) ? 1'b0 : 1'($urandom);
      steps = half ? 8 : 4;
      revs = 7'($urandom_range(1, 127));
      // The first phase runs long enough to see the LED move twice; the others stay short.
      ticks = (p == 0) ? CYCLES_PER_LED * steps * hold_now + 20 : DIRECTED_TICKS;
      run_move(revs, ccw, half, ticks);

      repeat (RANDOM_REQUESTS / NUM_PHASES) send(random_req());
    end

    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/smseq_pkg.sv
src/stepper_move_sequencer.sv
src/smseq_checker.sv
tb/smseq_checker.sv
tb/tb.sv
